@@ rtl/life_grid_generation_step_unit_macros.svh @@
// Assertion helpers for the life grid step unit.
`ifndef LIFE_GRID_GENERATION_STEP_UNIT_MACROS_SVH
`define LIFE_GRID_GENERATION_STEP_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LGS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lgs check failed");

// Next-cycle implication, disabled during reset.
`define LGS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lgs check failed");

`endif

@@ rtl/lgs_pkg.sv @@
`default_nettype none

package lgs_pkg;

    localparam int GRID_WIDTH  = 32;
    localparam int GRID_HEIGHT = 32;
    localparam int OUT_ROWS    = (GRID_HEIGHT < 32) ? GRID_HEIGHT : 32;
    localparam int ROW_AW      = $clog2(GRID_HEIGHT);
    localparam int CNT_W       = $clog2(GRID_HEIGHT + 1);

    typedef logic [GRID_WIDTH-1:0] t_row;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TGL,
        S_GFILL,
        S_GEN
    } t_state;

    typedef struct packed {
        logic       mode;
        logic [4:0] col;
        logic [4:0] row;
    } t_in;

    typedef struct packed {
        logic [4:0]  row_index;
        logic [31:0] row_bits;
        logic        last;
    } t_out;

endpackage

`default_nettype wire

@@ rtl/life_grid_generation_step_unit.sv @@
// Toggle: read the row, then register the toggled row as one beat with last set.
// Generation: after a fill reading rows 0 and 1, one row beat per cycle unless stalled;
// the one-read, one-write row memory and 3-row window set one row per cycle.
// Next item accepted once the previous item's last row is computed.
// Reset (sync, active low) clears all row valid bits: every cell reads dead.
`default_nettype none

module life_grid_generation_step_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lgs_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output lgs_pkg::t_out      o_out_data
);

    lgs_pkg::t_state r_state, n_state;
    logic [lgs_pkg::CNT_W-1:0] r_cnt, n_cnt;
    lgs_pkg::t_row r_up, n_up, r_mid, n_mid;
    logic [4:0] r_col, r_row;

    lgs_pkg::t_row r_mem [lgs_pkg::GRID_HEIGHT];
    logic [lgs_pkg::GRID_HEIGHT-1:0] r_vld;
    lgs_pkg::t_row r_rd_data;
    logic r_rd_vld;

    logic r_ovld;
    lgs_pkg::t_out r_out;

    logic c_accept, c_step;
    logic c_rd_en, c_wr_en, c_emit;
    logic [lgs_pkg::ROW_AW-1:0] c_rd_addr, c_wr_addr;
    lgs_pkg::t_row c_wr_data, c_rd_row, c_dn, c_new, c_tgl_row;
    logic [lgs_pkg::CNT_W-1:0] c_idx;
    lgs_pkg::t_out n_out;
    logic c_cnt_ok;

    assign c_accept    = i_in_valid && o_in_ready;
    assign c_step      = !r_ovld || i_out_ready;
    assign c_rd_row    = r_rd_vld ? r_rd_data : '0;
    assign c_idx       = r_cnt - 1'b1;
    assign o_in_ready  = (r_state == lgs_pkg::S_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;
    assign c_cnt_ok    = (r_cnt != '0) && (r_cnt <= lgs_pkg::CNT_W'(lgs_pkg::GRID_HEIGHT));

    // bottom neighbor row, dead beyond the last row
    assign c_dn = (r_cnt < lgs_pkg::CNT_W'(lgs_pkg::GRID_HEIGHT)) ? c_rd_row : '0;

    // shared row update unit
    always_comb begin
        logic [lgs_pkg::GRID_WIDTH+1:0] u, m, d;
        logic [3:0] n;
        u = {1'b0, r_up, 1'b0};
        m = {1'b0, r_mid, 1'b0};
        d = {1'b0, c_dn, 1'b0};
        c_new = '0;
        for (int c = 0; c < lgs_pkg::GRID_WIDTH; c++) begin
            n = 4'(u[c]) + 4'(u[c+1]) + 4'(u[c+2]) + 4'(m[c]) + 4'(m[c+2])
              + 4'(d[c]) + 4'(d[c+1]) + 4'(d[c+2]);
            c_new[c] = (n == 4'd3) || (m[c+1] && (n == 4'd2));
        end
    end

    always_comb begin
        c_tgl_row = c_rd_row;
        if (int'(r_col) < lgs_pkg::GRID_WIDTH) begin
            c_tgl_row = c_rd_row ^ (lgs_pkg::t_row'(1) << r_col);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lgs_pkg::S_IDLE: begin
                if (c_accept) begin
                    n_state = i_in_data.mode ? lgs_pkg::S_GFILL : lgs_pkg::S_TGL;
                end
            end
            lgs_pkg::S_TGL: begin
                if (c_step) begin
                    n_state = lgs_pkg::S_IDLE;
                end
            end
            lgs_pkg::S_GFILL: begin
                n_state = lgs_pkg::S_GEN;
            end
            lgs_pkg::S_GEN: begin
                if (c_step && (r_cnt == lgs_pkg::CNT_W'(lgs_pkg::GRID_HEIGHT))) begin
                    n_state = lgs_pkg::S_IDLE;
                end
            end
            default: n_state = lgs_pkg::S_IDLE;
        endcase
    end

    // datapath controls
    always_comb begin
        n_cnt     = r_cnt;
        n_up      = r_up;
        n_mid     = r_mid;
        c_rd_en   = 1'b0;
        c_rd_addr = '0;
        c_wr_en   = 1'b0;
        c_wr_addr = '0;
        c_wr_data = c_new;
        c_emit    = 1'b0;
        n_out     = r_out;
        unique case (r_state)
            lgs_pkg::S_IDLE: begin
                if (c_accept) begin
                    c_rd_en   = 1'b1;
                    c_rd_addr = i_in_data.mode ? '0 : lgs_pkg::ROW_AW'(i_in_data.row);
                    n_up      = '0;
                    n_cnt     = '0;
                end
            end
            lgs_pkg::S_TGL: begin
                if (c_step) begin
                    c_emit          = 1'b1;
                    n_out.row_index = r_row;
                    n_out.last      = 1'b1;
                    n_out.row_bits  = '0;
                    if (int'(r_row) < lgs_pkg::GRID_HEIGHT) begin
                        c_wr_en        = 1'b1;
                        c_wr_addr      = lgs_pkg::ROW_AW'(r_row);
                        c_wr_data      = c_tgl_row;
                        n_out.row_bits = 32'(c_tgl_row);
                    end
                end
            end
            lgs_pkg::S_GFILL: begin
                n_mid     = c_rd_row;
                c_rd_en   = 1'b1;
                c_rd_addr = lgs_pkg::ROW_AW'(1);
                n_cnt     = lgs_pkg::CNT_W'(1);
            end
            lgs_pkg::S_GEN: begin
                if (c_step) begin
                    c_wr_en   = 1'b1;
                    c_wr_addr = lgs_pkg::ROW_AW'(c_idx);
                    c_wr_data = c_new;
                    n_up      = r_mid;
                    n_mid     = c_dn;
                    n_cnt     = r_cnt + 1'b1;
                    if ((r_cnt + 1'b1) < lgs_pkg::CNT_W'(lgs_pkg::GRID_HEIGHT)) begin
                        c_rd_en   = 1'b1;
                        c_rd_addr = lgs_pkg::ROW_AW'(r_cnt + 1'b1);
                    end
                    if (c_idx < lgs_pkg::CNT_W'(lgs_pkg::OUT_ROWS)) begin
                        c_emit          = 1'b1;
                        n_out.row_index = 5'(c_idx);
                        n_out.row_bits  = 32'(c_new);
                        n_out.last      = (c_idx == lgs_pkg::CNT_W'(lgs_pkg::OUT_ROWS - 1));
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lgs_pkg::S_IDLE;
            r_ovld  <= 1'b0;
            r_vld   <= '0;
        end else begin
            r_state <= n_state;
            if (c_step) begin
                r_ovld <= c_emit;
            end
            if (c_wr_en) begin
                r_vld[c_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_up  <= n_up;
        r_mid <= n_mid;
        if (c_step) begin
            r_out <= n_out;
        end
        if (c_accept) begin
            r_col <= i_in_data.col;
            r_row <= i_in_data.row;
        end
    end

    // row memory
    always_ff @(posedge i_clk) begin
        if (c_wr_en) begin
            r_mem[c_wr_addr] <= c_wr_data;
        end
        if (c_rd_en) begin
            r_rd_data <= r_mem[c_rd_addr];
            r_rd_vld  <= r_vld[c_rd_addr];
        end
    end

`include "life_grid_generation_step_unit_macros.svh"

    `LGS_ASSERT_NEXT(a_gen_fill, c_accept && i_in_data.mode, r_state == lgs_pkg::S_GFILL)
    `LGS_ASSERT_NOW(a_cnt_range, r_state == lgs_pkg::S_GEN, c_cnt_ok)
    `LGS_ASSERT_NEXT(a_last_idle, c_step && c_emit && n_out.last, r_state == lgs_pkg::S_IDLE)
    `LGS_ASSERT_NOW(a_no_rw_clash, c_rd_en && c_wr_en, c_rd_addr != c_wr_addr)

endmodule

`default_nettype wire

@@ test/testbench.sv @@
module testbench;

    localparam logic MODE_TOGGLE  = 1'b0;
    localparam logic MODE_STEP    = 1'b1;
    localparam int   HOLD_CYCLES  = 400;
    localparam int   DRAIN_CYCLES = lgs_pkg::GRID_HEIGHT + 16;
    localparam int   CYCLE_LIMIT  = 200000;

    typedef enum int {
        SHAPE_GLIDER,
        SHAPE_BLINKER,
        SHAPE_BLOCK,
        SHAPE_BURST
    } t_shape;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic          in_valid  = 1'b0;
    lgs_pkg::t_in  in_data   = '0;
    logic          out_ready = 1'b0;
    logic          in_ready;
    logic          out_valid;
    lgs_pkg::t_out out_data;

    lgs_pkg::t_in  pending_cmds[$];
    lgs_pkg::t_out expected_rows[$];
    lgs_pkg::t_row life_cells[lgs_pkg::GRID_HEIGHT];

    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_seq      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int cycle_cnt     = 0;
    int queued_cmds   = 0;
    int fails         = 0;
    int n_toggles     = 0;
    int n_steps       = 0;
    int n_beats       = 0;

    life_grid_generation_step_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // B3/S23, cells beyond the border read as dead
    task automatic advance_generation();
        lgs_pkg::t_row nxt[lgs_pkg::GRID_HEIGHT];
        int   n;
        int   rr;
        int   cc;
        for (int r = 0; r < lgs_pkg::GRID_HEIGHT; r++) begin
            for (int c = 0; c < lgs_pkg::GRID_WIDTH; c++) begin
                n = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        rr = r + dr;
                        cc = c + dc;
                        if ((dr != 0 || dc != 0) && rr >= 0 && rr < lgs_pkg::GRID_HEIGHT &&
                            cc >= 0 && cc < lgs_pkg::GRID_WIDTH)
                            n += life_cells[rr][cc];
                    end
                end
                nxt[r][c] = (n == 3) || (life_cells[r][c] && n == 2);
            end
        end
        for (int r = 0; r < lgs_pkg::GRID_HEIGHT; r++)
            life_cells[r] = nxt[r];
    endtask

    task automatic predict_rows(input lgs_pkg::t_in cmd);
        lgs_pkg::t_out beat;
        if (cmd.mode == MODE_TOGGLE) begin
            beat.row_index = cmd.row;
            beat.row_bits  = '0;
            beat.last      = 1'b1;
            if (int'(cmd.row) < lgs_pkg::GRID_HEIGHT) begin
                if (int'(cmd.col) < lgs_pkg::GRID_WIDTH)
                    life_cells[cmd.row][cmd.col] = ~life_cells[cmd.row][cmd.col];
                beat.row_bits = life_cells[cmd.row];
            end
            expected_rows.push_back(beat);
            n_toggles++;
        end else begin
            advance_generation();
            for (int r = 0; r < lgs_pkg::OUT_ROWS; r++) begin
                beat.row_index = r[4:0];
                beat.row_bits  = life_cells[r];
                beat.last      = (r == lgs_pkg::OUT_ROWS - 1);
                expected_rows.push_back(beat);
            end
            n_steps++;
        end
    endtask

    task automatic push_toggle(input logic [4:0] c, input logic [4:0] r);
        lgs_pkg::t_in cmd;
        cmd.mode = MODE_TOGGLE;
        cmd.col  = c;
        cmd.row  = r;
        pending_cmds.push_back(cmd);
        queued_cmds++;
    endtask

    // col/row are don't-care for a step; drive them random anyway
    task automatic push_step();
        lgs_pkg::t_in cmd;
        cmd.mode = MODE_STEP;
        cmd.col  = $urandom_range(0, 31);
        cmd.row  = $urandom_range(0, 31);
        pending_cmds.push_back(cmd);
        queued_cmds++;
    endtask

    // placement wraps in 5 bits, so shapes may straddle the border
    task automatic push_shape(input t_shape shape, input logic [4:0] c, input logic [4:0] r);
        case (shape)
            SHAPE_GLIDER: begin
                push_toggle(c + 5'd1, r);
                push_toggle(c + 5'd2, r + 5'd1);
                push_toggle(c,        r + 5'd2);
                push_toggle(c + 5'd1, r + 5'd2);
                push_toggle(c + 5'd2, r + 5'd2);
            end
            SHAPE_BLINKER: begin
                push_toggle(c,        r);
                push_toggle(c + 5'd1, r);
                push_toggle(c + 5'd2, r);
            end
            SHAPE_BLOCK: begin
                push_toggle(c,        r);
                push_toggle(c + 5'd1, r);
                push_toggle(c,        r + 5'd1);
                push_toggle(c + 5'd1, r + 5'd1);
            end
            default: begin
                repeat ($urandom_range(3, 6))
                    push_toggle(c + 5'($urandom_range(0, 3)), r + 5'($urandom_range(0, 3)));
            end
        endcase
    endtask

    task automatic add_random_cmds(input int count);
        int target;
        int sel;
        target = queued_cmds + count;
        while (queued_cmds < target) begin
            sel = $urandom_range(0, 99);
            if (sel < 20) begin
                push_step();
            end else if (sel < 55) begin
                push_shape(t_shape'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                           5'($urandom_range(0, 31)));
                repeat ($urandom_range(1, 2))
                    push_step();
            end else begin
                push_toggle(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || in_valid || expected_rows.size() != 0)
            @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end else begin
            if (in_valid && in_ready)
                predict_rows(in_data);
            if (!in_valid || in_ready) begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    in_data  <= pending_cmds.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        lgs_pkg::t_out want;
        if (i_rst_n && out_valid && out_ready) begin
            n_beats++;
            if (expected_rows.size() == 0) begin
                $error("unexpected beat: row_index %0d row_bits %h last %0d",
                       out_data.row_index, out_data.row_bits, out_data.last);
                fails++;
            end else begin
                want = expected_rows.pop_front();
                if (out_data.row_index !== want.row_index) begin
                    $error("row_index: expected %0d, got %0d", want.row_index,
                           out_data.row_index);
                    fails++;
                end
                if (out_data.row_bits !== want.row_bits) begin
                    $error("row_bits: expected %h, got %h", want.row_bits, out_data.row_bits);
                    fails++;
                end
                if (out_data.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, out_data.last);
                    fails++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        for (int r = 0; r < lgs_pkg::GRID_HEIGHT; r++)
            life_cells[r] = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // corners, then lone cells die
        push_toggle(5'd0,  5'd0);
        push_toggle(5'd31, 5'd0);
        push_toggle(5'd0,  5'd31);
        push_toggle(5'd31, 5'd31);
        push_step();
        // blinker on the top edge loses its upper arm
        push_shape(SHAPE_BLINKER, 5'd10, 5'd0);
        push_step();
        push_step();
        // still life in the bottom-right corner
        push_shape(SHAPE_BLOCK, 5'd30, 5'd30);
        push_step();
        // set and clear the same cell
        push_toggle(5'd5, 5'd5);
        push_toggle(5'd5, 5'd5);
        // glider against the left edge
        push_shape(SHAPE_GLIDER, 5'd0, 5'd14);
        push_step();
        push_step();
        wait_idle();

        hold_seq = hold_seq + 1;
        add_random_cmds(25);
        wait_idle();

        src_idle_pct = 50;
        add_random_cmds(25);
        wait_idle();

        src_idle_pct  = 0;
        snk_stall_pct = 50;
        add_random_cmds(25);
        wait_idle();

        src_idle_pct  = 7;
        snk_stall_pct = 7;
        add_random_cmds(25);
        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d toggles and %0d generation steps, %0d row beats checked",
                 n_toggles, n_steps, n_beats);
        $display("phases: free-running, long output hold, input gaps, output stalls, mixed");
        if (fails == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/lgs_pkg.sv
rtl/life_grid_generation_step_unit.sv
test/testbench.sv
